// File: hw/rtl/configurable_crc_engine_core_defines.svh
// Assertion macros for the configurable CRC engine.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef CONFIGURABLE_CRC_ENGINE_CORE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_CORE_DEFINES_SVH

// Checked only out of reset.
`define CCRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CCRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ccrc_pkg.sv
// Shared types and constants of the configurable CRC engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccrc_pkg;

  localparam int unsigned CrcW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_CRC8    = 2'd0,
    MODE_CRC16   = 2'd1,
    MODE_CRC32   = 2'd2,
    MODE_CRC32_B = 2'd3   // unused code, behaves as CRC-32
  } ccrc_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH_MODE  = 3'd0,
    REG_POLYNOMIAL  = 3'd1,
    REG_START_VALUE = 3'd2,
    REG_FINAL_XOR   = 3'd3
  } ccrc_reg_idx_t;

  localparam ccrc_mode_t     RstMode  = MODE_CRC32;
  localparam logic [CrcW-1:0] RstPoly  = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] RstStart = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] RstFxor  = 32'hFFFF_FFFF;

  typedef struct packed {
    ccrc_mode_t      mode;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] start;
    logic [CrcW-1:0] fxor;
  } ccrc_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/ccrc_if.sv
// Valid/ready channel interfaces for the CRC engine input and result words.
// Depends on ccrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ccrc_in_if
  import ccrc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             byte_valid;
  logic             last;

  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface ccrc_out_if
  import ccrc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CrcW-1:0] crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ccrc_cfg.sv
// Configuration register file: width mode, polynomial, start value, final XOR.
// Depends on ccrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_cfg
  import ccrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output ccrc_cfg_t                cfg
);

  ccrc_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (ccrc_reg_idx_t'(cfg_index))
        REG_WIDTH_MODE:  cfg_nxt.mode  = ccrc_mode_t'(cfg_wdata[ModeW-1:0]);
        REG_POLYNOMIAL:  cfg_nxt.poly  = cfg_wdata[CrcW-1:0];
        REG_START_VALUE: cfg_nxt.start = cfg_wdata[CrcW-1:0];
        REG_FINAL_XOR:   cfg_nxt.fxor  = cfg_wdata[CrcW-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= RstMode;
      cfg_r.poly  <= RstPoly;
      cfg_r.start <= RstStart;
      cfg_r.fxor  <= RstFxor;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hw/rtl/ccrc_step.sv
// One-word CRC update: start-value load, eight unrolled shift/XOR steps,
// and result finishing (final XOR, mask, 32-bit reflection). Depends on ccrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_step
  import ccrc_pkg::*;
(
  input  ccrc_cfg_t              cfg,
  input  wire logic [CrcW-1:0]   crc_cur,
  input  wire logic              msg_open,
  input  wire logic [ByteW-1:0]  data_byte,
  input  wire logic              byte_valid,
  output logic      [CrcW-1:0]   crc_upd,
  output logic      [CrcW-1:0]   crc_result
);

  logic [CrcW-1:0]  mask;
  logic [CrcW-1:0]  poly_m;
  logic [CrcW-1:0]  base;
  logic [CrcW-1:0]  crc;
  logic [CrcW-1:0]  fin;
  logic [ByteW-1:0] rev_byte;
  logic [ByteW-1:0] t;
  logic             msb;

  always_comb begin
    case (cfg.mode)
      MODE_CRC8:  mask = 32'h0000_00FF;
      MODE_CRC16: mask = 32'h0000_FFFF;
      default:    mask = 32'hFFFF_FFFF;
    endcase
  end

  // byte bit reversal by nibble, pair and bit swaps
  always_comb begin
    t = data_byte;
    t = ((t & 8'hF0) >> 4) | ((t & 8'h0F) << 4);
    t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
    t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
    rev_byte = t;
  end

  always_comb begin
    msb    = 1'b0;
    poly_m = cfg.poly & mask;
    base   = msg_open ? crc_cur : (cfg.start & mask);
    crc    = base & mask;
    if (byte_valid) begin
      case (cfg.mode)
        MODE_CRC8:  crc = crc ^ {24'd0, data_byte};
        MODE_CRC16: crc = crc ^ {16'd0, data_byte, 8'd0};
        default:    crc = crc ^ {rev_byte, 24'd0};
      endcase
      for (int i = 0; i < ByteW; i++) begin
        case (cfg.mode)
          MODE_CRC8:  msb = crc[7];
          MODE_CRC16: msb = crc[15];
          default:    msb = crc[CrcW-1];
        endcase
        crc = ((crc << 1) ^ (msb ? poly_m : '0)) & mask;
      end
    end
    // a word without a byte passes the running value (or the start value at message start) through unshifted
    crc_upd = byte_valid ? crc : base;

    fin        = (crc ^ cfg.fxor) & mask;
    crc_result = fin;
    if (cfg.mode != MODE_CRC8 && cfg.mode != MODE_CRC16) begin
      for (int j = 0; j < CrcW; j++) begin
        crc_result[j] = fin[CrcW-1-j];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/configurable_crc_engine_core.sv
// Top level of the configurable CRC engine (8/16/32-bit CRC over a byte stream).
// Depends on ccrc_pkg, ccrc_if, ccrc_cfg, ccrc_step and the defines header.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+------------------------------------
//   in_ch    | in  | valid/ready | data_byte[7:0], byte_valid, last
//   out_ch   | out | valid/ready | crc_value[31:0]
//   cfg_*    | in  | cfg_we      | cfg_index[2:0], cfg_wdata[31:0]
//
// One word per cycle: the CRC register absorbs a whole byte in the cycle it
// is accepted (eight unrolled shift/XOR steps). A last word loads the result
// register, which shows the CRC on the next cycle. in_ch stalls only while a
// result waits in the output register and out_ch is not ready.
// Synchronous active-low reset clears the message flag, output valid and CRC register and loads the config defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "configurable_crc_engine_core_defines.svh"

module configurable_crc_engine_core
  import ccrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  ccrc_in_if.sink                  in_ch,
  ccrc_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  ccrc_cfg_t       cfg;
  logic [CrcW-1:0] crc_r, crc_nxt;
  logic            in_msg_r, in_msg_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CrcW-1:0] out_crc_r, out_crc_nxt;
  logic [CrcW-1:0] crc_upd;
  logic [CrcW-1:0] crc_result;
  logic            in_acc;

  ccrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccrc_step u_step (
    .cfg        (cfg),
    .crc_cur    (crc_r),
    .msg_open   (in_msg_r),
    .data_byte  (in_ch.data_byte),
    .byte_valid (in_ch.byte_valid),
    .crc_upd    (crc_upd),
    .crc_result (crc_result)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    crc_nxt       = crc_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = out_valid_r;
    out_crc_nxt   = out_crc_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      crc_nxt    = crc_upd;
      in_msg_nxt = !in_ch.last;
      if (in_ch.last) begin
        out_valid_nxt = 1'b1;
        out_crc_nxt   = crc_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
    end else begin
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r       <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_crc_r <= out_crc_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.crc_value = out_crc_r;

  `CCRC_ASSERT(a_result_from_last, $rose(out_valid_r) |-> $past(in_acc && in_ch.last), "result word without an accepted last word")
  `CCRC_ASSERT(a_last_closes_msg, (in_acc && in_ch.last) |=> !in_msg_r, "message still open after last word")
  `CCRC_ASSERT(a_ready_when_empty, !out_valid_r |-> in_ch.ready, "input stalled with empty output register")
  `CCRC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && !in_msg_r), "reset left result or message state")

endmodule

`default_nettype wire
